// ===== hdl/ngpp_pkg.sv =====
// ----------------------------------------------------------------------------
// NMEA GGA position parser package
// Shared types, character codes and arithmetic constants for the parser.
// ----------------------------------------------------------------------------
`default_nettype none

package ngpp_pkg;

    // Sentence field sequencing after the header has been found.
    typedef enum logic [2:0] {
        FIELD_SKIP_ONE = 3'd0,
        FIELD_TIME     = 3'd1,
        FIELD_LAT      = 3'd2,
        FIELD_NS       = 3'd3,
        FIELD_LON      = 3'd4,
        FIELD_EW       = 3'd5,
        FIELD_DONE     = 3'd6
    } field_t;

    localparam int CHAR_W    = 8;
    localparam int INT_W     = 17;
    localparam int ACC_W     = 20;
    localparam int DEG_W     = 11;
    localparam int WHOLE_W   = 10;
    localparam int MATCH_W   = 3;

    localparam logic [MATCH_W-1:0] HEADER_LEN = 3'd6;
    localparam logic [INT_W-1:0]   INT_PART_MAX = 17'd99999;

    // floor(x / 100) == (x * DIV100_MULT) >> DIV100_SHIFT for x <= 99999.
    localparam int PROD_W        = 35;
    localparam int DIV100_SHIFT  = 24;
    localparam logic [PROD_W-1:0] DIV100_MULT = 35'd167773;

    localparam logic [CHAR_W-1:0] CH_NUL    = 8'h00;
    localparam logic [CHAR_W-1:0] CH_DOLLAR = 8'h24;
    localparam logic [CHAR_W-1:0] CH_COMMA  = 8'h2C;
    localparam logic [CHAR_W-1:0] CH_DOT    = 8'h2E;
    localparam logic [CHAR_W-1:0] CH_ZERO   = 8'h30;
    localparam logic [CHAR_W-1:0] CH_NINE   = 8'h39;
    localparam logic [CHAR_W-1:0] CH_A      = 8'h41;
    localparam logic [CHAR_W-1:0] CH_G      = 8'h47;
    localparam logic [CHAR_W-1:0] CH_P      = 8'h50;
    localparam logic [CHAR_W-1:0] CH_S      = 8'h53;
    localparam logic [CHAR_W-1:0] CH_W      = 8'h57;

    // Expected character at each position of the "$GPGGA" header.
    function automatic logic [CHAR_W-1:0] header_char(input logic [MATCH_W-1:0] idx);
        logic [CHAR_W-1:0] ch;
        case (idx)
            3'd0:    ch = CH_DOLLAR;
            3'd1:    ch = CH_G;
            3'd2:    ch = CH_P;
            3'd3:    ch = CH_G;
            3'd4:    ch = CH_G;
            3'd5:    ch = CH_A;
            default: ch = CH_NUL;
        endcase
        return ch;
    endfunction

    // Per-field number accumulator state.
    typedef struct packed {
        logic [INT_W-1:0] ip;
        logic             nz;
        logic             dot;
        logic             stop;
    } num_t;

endpackage

`default_nettype wire

// ===== hdl/ngpp_in_if.sv =====
// ----------------------------------------------------------------------------
// NMEA character stream channel
// Carries one datagram byte per word with a final-byte flag.
// ----------------------------------------------------------------------------
`default_nettype none

interface ngpp_in_if;
    logic                        valid;
    logic                        ready;
    logic [ngpp_pkg::CHAR_W-1:0] char_byte;
    logic                        end_of_message;

    modport source (output valid, output char_byte, output end_of_message, input ready);
    modport sink   (input valid, input char_byte, input end_of_message, output ready);
endinterface

`default_nettype wire

// ===== hdl/ngpp_out_if.sv =====
// ----------------------------------------------------------------------------
// NMEA position result channel
// Carries one position word per datagram.
// ----------------------------------------------------------------------------
`default_nettype none

interface ngpp_out_if;
    logic                              valid;
    logic                              ready;
    logic signed [ngpp_pkg::DEG_W-1:0] lat_degrees;
    logic signed [ngpp_pkg::DEG_W-1:0] lon_degrees;
    logic                              position_valid;

    modport source (output valid, output lat_degrees, output lon_degrees,
                    output position_valid, input ready);
    modport sink   (input valid, input lat_degrees, input lon_degrees,
                    input position_valid, output ready);
endinterface

`default_nettype wire

// ===== hdl/nmea_gga_position_parser_top.sv =====
// ----------------------------------------------------------------------------
// NMEA GGA position parser
// Extracts whole latitude and longitude degrees from a GGA sentence.
// ----------------------------------------------------------------------------
//  Channel       Dir  Word contents
//  char_stream   in   char_byte[7:0], end_of_message
//  position      out  lat_degrees[10:0], lon_degrees[10:0], position_valid
//
//  One byte is accepted per cycle while ready is high; a result passes from the input
//  register through the snapshot register (parse/snapshot) into the output (divide-by-100).
//  Reset clears the parser state and all pipeline valid flags.
//  Bytes that are not last keep flowing while a result waits at the output;
//  a last byte waits in the input register only while the snapshot stage is
//  full and the output word is stalled.
// ----------------------------------------------------------------------------
`default_nettype none

module nmea_gga_position_parser_top (
    input  wire logic   clk,
    input  wire logic   rst_n,
    ngpp_in_if.sink     char_stream,
    ngpp_out_if.source  position
);

    localparam int CW = ngpp_pkg::CHAR_W;
    localparam int IW = ngpp_pkg::INT_W;
    localparam int MW = ngpp_pkg::MATCH_W;
    localparam int DW = ngpp_pkg::DEG_W;
    localparam int WW = ngpp_pkg::WHOLE_W;
    localparam int PW = ngpp_pkg::PROD_W;
    localparam int SH = ngpp_pkg::DIV100_SHIFT;

    // Digit accumulation for one coordinate field.
    function automatic ngpp_pkg::num_t num_char(input ngpp_pkg::num_t s,
                                                input logic [CW-1:0] c);
        ngpp_pkg::num_t           r;
        logic [ngpp_pkg::ACC_W-1:0] v;
        logic [3:0]               d;
        r = s;
        d = c[3:0];
        v = ({3'b000, s.ip} << 3) + ({3'b000, s.ip} << 1) + {16'd0, d};
        if (!s.stop)
        begin
            if (c >= ngpp_pkg::CH_ZERO && c <= ngpp_pkg::CH_NINE)
            begin
                if (!s.dot)
                begin
                    r.ip = (v > {3'b000, ngpp_pkg::INT_PART_MAX}) ?
                           ngpp_pkg::INT_PART_MAX : v[IW-1:0];
                end
                if (d != 4'd0)
                begin
                    r.nz = 1'b1;
                end
            end
            else if (c == ngpp_pkg::CH_DOT && !s.dot)
            begin
                r.dot = 1'b1;
            end
            else
            begin
                r.stop = 1'b1;
            end
        end
        return r;
    endfunction

    // ---------------- input register ----------------
    logic          in_valid_reg;
    logic [CW-1:0] in_char_reg;
    logic          in_last_reg;

    // ---------------- parser state ----------------
    logic [MW-1:0]    match_reg, match_next;
    ngpp_pkg::field_t field_reg, field_next;
    logic [IW-1:0]    lat_ip_reg, lat_ip_next;
    logic [IW-1:0]    lon_ip_reg, lon_ip_next;
    logic             lat_nz_reg, lat_nz_next;
    logic             lon_nz_reg, lon_nz_next;
    logic             lat_south_reg, lat_south_next;
    logic             lon_west_reg, lon_west_next;
    logic             dot_reg, dot_next;
    logic             stop_reg, stop_next;
    logic             first_reg, first_next;
    logic             ended_reg, ended_next;

    // ---------------- snapshot register ----------------
    logic          snap_valid_reg;
    logic          snap_pos_reg, snap_pos_next;
    logic [IW-1:0] snap_lat_ip_reg, snap_lat_ip_next;
    logic [IW-1:0] snap_lon_ip_reg, snap_lon_ip_next;
    logic          snap_lat_neg_reg, snap_lat_neg_next;
    logic          snap_lon_neg_reg, snap_lon_neg_next;

    // ---------------- output register ----------------
    logic          out_valid_reg;
    logic [DW-1:0] out_lat_reg, out_lat_next;
    logic [DW-1:0] out_lon_reg, out_lon_next;
    logic          out_pos_reg;

    logic c_adv, s_free, b_go, a_free;

    assign c_adv  = !out_valid_reg || position.ready;
    assign s_free = !snap_valid_reg || c_adv;
    assign b_go   = in_valid_reg && (!in_last_reg || s_free);
    assign a_free = !in_valid_reg || b_go;

    assign char_stream.ready       = a_free;
    assign position.valid          = out_valid_reg;
    assign position.lat_degrees    = out_lat_reg;
    assign position.lon_degrees    = out_lon_reg;
    assign position.position_valid = out_pos_reg;

    // Parse one byte, then on the last byte capture the result and clear.
    always_comb
    begin
        ngpp_pkg::num_t ns;
        logic           pos_now;
        match_next     = match_reg;
        field_next     = field_reg;
        lat_ip_next    = lat_ip_reg;
        lon_ip_next    = lon_ip_reg;
        lat_nz_next    = lat_nz_reg;
        lon_nz_next    = lon_nz_reg;
        lat_south_next = lat_south_reg;
        lon_west_next  = lon_west_reg;
        dot_next       = dot_reg;
        stop_next      = stop_reg;
        first_next     = first_reg;
        ended_next     = ended_reg;
        ns             = '0;
        pos_now        = 1'b0;

        if (b_go && !ended_reg)
        begin
            if (in_char_reg == ngpp_pkg::CH_NUL)
            begin
                ended_next = 1'b1;
            end
            else if (match_reg < ngpp_pkg::HEADER_LEN)
            begin
                if (in_char_reg == ngpp_pkg::header_char(match_reg))
                    match_next = match_reg + 3'd1;
                else if (in_char_reg == ngpp_pkg::CH_DOLLAR)
                    match_next = 3'd1;
                else
                    match_next = 3'd0;
            end
            else
            begin
                unique case (field_reg)
                    ngpp_pkg::FIELD_SKIP_ONE:
                    begin
                        field_next = ngpp_pkg::FIELD_TIME;
                    end
                    ngpp_pkg::FIELD_TIME:
                    begin
                        if (in_char_reg == ngpp_pkg::CH_COMMA)
                        begin
                            field_next = ngpp_pkg::FIELD_LAT;
                            first_next = 1'b1;
                            dot_next   = 1'b0;
                            stop_next  = 1'b0;
                        end
                    end
                    ngpp_pkg::FIELD_LAT:
                    begin
                        if (in_char_reg == ngpp_pkg::CH_COMMA)
                        begin
                            field_next = ngpp_pkg::FIELD_NS;
                            first_next = 1'b1;
                            dot_next   = 1'b0;
                            stop_next  = 1'b0;
                        end
                        else
                        begin
                            ns = num_char({lat_ip_reg, lat_nz_reg, dot_reg, stop_reg},
                                          in_char_reg);
                            lat_ip_next = ns.ip;
                            lat_nz_next = ns.nz;
                            dot_next    = ns.dot;
                            stop_next   = ns.stop;
                        end
                    end
                    ngpp_pkg::FIELD_NS:
                    begin
                        if (first_reg)
                        begin
                            lat_south_next = (in_char_reg == ngpp_pkg::CH_S);
                            first_next     = 1'b0;
                        end
                        if (in_char_reg == ngpp_pkg::CH_COMMA)
                        begin
                            field_next = ngpp_pkg::FIELD_LON;
                            first_next = 1'b1;
                            dot_next   = 1'b0;
                            stop_next  = 1'b0;
                        end
                    end
                    ngpp_pkg::FIELD_LON:
                    begin
                        if (in_char_reg == ngpp_pkg::CH_COMMA)
                        begin
                            field_next = ngpp_pkg::FIELD_EW;
                            first_next = 1'b1;
                            dot_next   = 1'b0;
                            stop_next  = 1'b0;
                        end
                        else
                        begin
                            ns = num_char({lon_ip_reg, lon_nz_reg, dot_reg, stop_reg},
                                          in_char_reg);
                            lon_ip_next = ns.ip;
                            lon_nz_next = ns.nz;
                            dot_next    = ns.dot;
                            stop_next   = ns.stop;
                        end
                    end
                    ngpp_pkg::FIELD_EW:
                    begin
                        lon_west_next = (in_char_reg == ngpp_pkg::CH_W);
                        field_next    = ngpp_pkg::FIELD_DONE;
                    end
                    default:
                    begin
                    end
                endcase
            end
        end

        pos_now = (match_next >= ngpp_pkg::HEADER_LEN) &&
                  (field_next >= ngpp_pkg::FIELD_EW) && (lat_nz_next || lon_nz_next);

        // An invalid result is stored as zero so the output stage needs no mux.
        snap_pos_next     = pos_now;
        snap_lat_ip_next  = pos_now ? lat_ip_next : '0;
        snap_lon_ip_next  = pos_now ? lon_ip_next : '0;
        snap_lat_neg_next = pos_now && lat_south_next && lat_nz_next;
        snap_lon_neg_next = pos_now && lon_west_next && lon_nz_next;

        if (b_go && in_last_reg)
        begin
            match_next     = '0;
            field_next     = ngpp_pkg::FIELD_SKIP_ONE;
            lat_ip_next    = '0;
            lon_ip_next    = '0;
            lat_nz_next    = 1'b0;
            lon_nz_next    = 1'b0;
            lat_south_next = 1'b0;
            lon_west_next  = 1'b0;
            dot_next       = 1'b0;
            stop_next      = 1'b0;
            first_next     = 1'b1;
            ended_next     = 1'b0;
        end
    end

    // Whole degrees by reciprocal multiply; a negative value is -whole-1, i.e. ~whole.
    always_comb
    begin
        logic [PW-1:0] lat_prod;
        logic [PW-1:0] lon_prod;
        logic [DW-1:0] lat_whole;
        logic [DW-1:0] lon_whole;
        lat_prod  = PW'(snap_lat_ip_reg) * ngpp_pkg::DIV100_MULT;
        lon_prod  = PW'(snap_lon_ip_reg) * ngpp_pkg::DIV100_MULT;
        lat_whole = {1'b0, lat_prod[SH+WW-1:SH]};
        lon_whole = {1'b0, lon_prod[SH+WW-1:SH]};
        out_lat_next = snap_lat_neg_reg ? ~lat_whole : lat_whole;
        out_lon_next = snap_lon_neg_reg ? ~lon_whole : lon_whole;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg   <= 1'b0;
            snap_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
            match_reg      <= '0;
            field_reg      <= ngpp_pkg::FIELD_SKIP_ONE;
            lat_ip_reg     <= '0;
            lon_ip_reg     <= '0;
            lat_nz_reg     <= 1'b0;
            lon_nz_reg     <= 1'b0;
            lat_south_reg  <= 1'b0;
            lon_west_reg   <= 1'b0;
            dot_reg        <= 1'b0;
            stop_reg       <= 1'b0;
            first_reg      <= 1'b1;
            ended_reg      <= 1'b0;
        end
        else
        begin
            if (a_free)
            begin
                in_valid_reg <= char_stream.valid;
            end
            if (s_free)
            begin
                snap_valid_reg <= b_go && in_last_reg;
            end
            if (c_adv)
            begin
                out_valid_reg <= snap_valid_reg;
            end
            match_reg     <= match_next;
            field_reg     <= field_next;
            lat_ip_reg    <= lat_ip_next;
            lon_ip_reg    <= lon_ip_next;
            lat_nz_reg    <= lat_nz_next;
            lon_nz_reg    <= lon_nz_next;
            lat_south_reg <= lat_south_next;
            lon_west_reg  <= lon_west_next;
            dot_reg       <= dot_next;
            stop_reg      <= stop_next;
            first_reg     <= first_next;
            ended_reg     <= ended_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (a_free && char_stream.valid)
        begin
            in_char_reg <= char_stream.char_byte;
            in_last_reg <= char_stream.end_of_message;
        end
        if (b_go && in_last_reg)
        begin
            snap_pos_reg     <= snap_pos_next;
            snap_lat_ip_reg  <= snap_lat_ip_next;
            snap_lon_ip_reg  <= snap_lon_ip_next;
            snap_lat_neg_reg <= snap_lat_neg_next;
            snap_lon_neg_reg <= snap_lon_neg_next;
        end
        if (c_adv && snap_valid_reg)
        begin
            out_lat_reg <= out_lat_next;
            out_lon_reg <= out_lon_next;
            out_pos_reg <= snap_pos_reg;
        end
    end

`ifndef SYNTHESIS
    a_match_range: assert property (@(posedge clk) disable iff (!rst_n)
        match_reg <= ngpp_pkg::HEADER_LEN)
        else $error("header match progress out of range");

    a_fields_after_header: assert property (@(posedge clk) disable iff (!rst_n)
        field_reg != ngpp_pkg::FIELD_SKIP_ONE |-> match_reg == ngpp_pkg::HEADER_LEN)
        else $error("field sequencing started before the header matched");

    a_clear_after_last: assert property (@(posedge clk) disable iff (!rst_n)
        (b_go && in_last_reg) |=> (match_reg == '0 &&
                                   field_reg == ngpp_pkg::FIELD_SKIP_ONE && !ended_reg))
        else $error("parser state not cleared after the last byte");

    a_int_saturated: assert property (@(posedge clk) disable iff (!rst_n)
        lat_ip_reg <= ngpp_pkg::INT_PART_MAX && lon_ip_reg <= ngpp_pkg::INT_PART_MAX)
        else $error("integer part exceeded its saturation value");

    a_invalid_is_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && !out_pos_reg) |-> (out_lat_reg == '0 && out_lon_reg == '0))
        else $error("invalid position carries nonzero degrees");
`endif

endmodule

`default_nettype wire
